@@ design/time_date_field_parser_assert.svh @@
// Assertion macros shared by the time and date field parser.
`ifndef TIME_DATE_FIELD_PARSER_ASSERT_SVH
`define TIME_DATE_FIELD_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDFP_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDFP_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/tdfp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tdfp_pkg;

  localparam int unsigned MaxFractionDigits = 6;

  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiNine = 8'h39;
  localparam logic [7:0] AsciiDot  = 8'h2E;

  localparam logic [6:0]  YearPivot   = 7'd50;
  localparam logic [11:0] CenturyLow  = 12'd2000;
  localparam logic [11:0] CenturyHigh = 12'd1900;
  localparam logic [10:0] MsLimit     = 11'd999;

  localparam logic [4:0] MonthLen [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };
  localparam logic [4:0] LeapFebLen = 5'd29;
  localparam logic [3:0] MonthFeb   = 4'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic       last;
  } char_t;

  typedef struct packed {
    logic        ok;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
  } result_t;

  function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    len = 5'd0;
    if (month >= 4'd1 && month <= 4'd12) begin
      len = MonthLen[month - 4'd1];
      if (month == MonthFeb && leap) begin
        len = LeapFebLen;
      end
    end
    return len;
  endfunction

endpackage

`default_nettype wire

@@ design/tdfp_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface tdfp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ design/time_date_field_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "time_date_field_parser_assert.svh"

// Parses a ddmmyy date field followed by an hhmmss[.ffffff] time field, one ASCII character
// per transfer on chars, and delivers one checked date and time on result after the
// character marked last. The block takes one character every cycle; a character moves
// through an input register and then through a single stage that updates the digit
// accumulators and, on the last character, validates the record into the result register.
// Only a last character waits, and only while an earlier result is still held on result.
// Two-digit years below 50 map to 20xx and the rest to 19xx, days are checked against
// Gregorian month lengths, and fractions are rounded half up to milliseconds. When ok
// is low every other field is zero.
module time_date_field_parser
  import tdfp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  tdfp_stream_if.sink  chars,
  tdfp_stream_if.source result
);

  logic       char_valid;
  char_t      char_reg;
  logic       advance;

  logic       in_time_phase, in_time_phase_next;
  logic [2:0] date_count, date_count_next;
  logic [3:0] time_count, time_count_next;
  logic [6:0] day_acc, day_acc_next;
  logic [6:0] month_acc, month_acc_next;
  logic [6:0] year_acc, year_acc_next;
  logic [6:0] hour_acc, hour_acc_next;
  logic [6:0] minute_acc, minute_acc_next;
  logic [6:0] second_acc, second_acc_next;
  logic [9:0] fraction_acc, fraction_acc_next;
  logic       round_up, round_up_next;
  logic       bad_flag, bad_flag_next;

  logic       out_valid;
  result_t    out_data;
  result_t    result_next;

  logic        dig;
  logic [3:0]  digit;
  logic [3:0]  frac_index;
  logic [11:0] full_year;
  logic [10:0] ms_sum;
  logic        record_ok;

  function automatic logic [6:0] acc_digit(input logic [6:0] acc, input logic [3:0] d);
    return 7'((acc << 3) + (acc << 1) + {3'b000, d});
  endfunction

  assign advance     = char_valid && (!char_reg.last || !out_valid || result.ready);
  assign chars.ready = !char_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (chars.ready) begin
      char_valid <= chars.valid;
    end
    if (chars.ready && chars.valid) begin
      char_reg <= chars.payload;
    end
  end

  assign dig        = (char_reg.ch >= AsciiZero) && (char_reg.ch <= AsciiNine);
  assign digit      = dig ? char_reg.ch[3:0] : 4'd0;
  assign frac_index = time_count - 4'd6;

  always_comb begin
    in_time_phase_next = in_time_phase;
    date_count_next    = date_count;
    time_count_next    = time_count;
    day_acc_next       = day_acc;
    month_acc_next     = month_acc;
    year_acc_next      = year_acc;
    hour_acc_next      = hour_acc;
    minute_acc_next    = minute_acc;
    second_acc_next    = second_acc;
    fraction_acc_next  = fraction_acc;
    round_up_next      = round_up;
    bad_flag_next      = bad_flag;
    if (!char_reg.kind) begin
      if (in_time_phase) begin
        bad_flag_next = 1'b1;
      end else begin
        if (date_count >= 3'd6) begin
          bad_flag_next = 1'b1;
        end else begin
          if (!dig) begin
            bad_flag_next = 1'b1;
          end
          if (date_count < 3'd2) begin
            day_acc_next = acc_digit(day_acc, digit);
          end else if (date_count < 3'd4) begin
            month_acc_next = acc_digit(month_acc, digit);
          end else begin
            year_acc_next = acc_digit(year_acc, digit);
          end
        end
        if (date_count != 3'd7) begin
          date_count_next = date_count + 3'd1;
        end
      end
    end else begin
      in_time_phase_next = 1'b1;
      if (time_count == 4'd15) begin
        bad_flag_next = 1'b1;
      end else if (time_count < 4'd6) begin
        if (!dig) begin
          bad_flag_next = 1'b1;
        end
        if (time_count < 4'd2) begin
          hour_acc_next = acc_digit(hour_acc, digit);
        end else if (time_count < 4'd4) begin
          minute_acc_next = acc_digit(minute_acc, digit);
        end else begin
          second_acc_next = acc_digit(second_acc, digit);
        end
      end else if (time_count == 4'd6) begin
        if (char_reg.ch != AsciiDot) begin
          bad_flag_next = 1'b1;
        end
      end else begin
        if (32'(frac_index) > MaxFractionDigits || !dig) begin
          bad_flag_next = 1'b1;
        end
        case (frac_index)
          4'd1:    fraction_acc_next = fraction_acc + 10'(digit) * 10'd100;
          4'd2:    fraction_acc_next = fraction_acc + 10'(digit) * 10'd10;
          4'd3:    fraction_acc_next = fraction_acc + 10'(digit);
          4'd4:    round_up_next = (digit >= 4'd5);
          default: fraction_acc_next = fraction_acc;
        endcase
      end
      if (time_count != 4'd15) begin
        time_count_next = time_count + 4'd1;
      end
    end
  end

  // Every year multiple of four in 1950..2049 is a Gregorian leap year.
  assign full_year = (year_acc_next < YearPivot) ? CenturyLow + 12'(year_acc_next)
                                                 : CenturyHigh + 12'(year_acc_next);
  assign ms_sum    = 11'(fraction_acc_next) + 11'(round_up_next);
  assign record_ok = !bad_flag_next && (date_count_next == 3'd6) && (time_count_next >= 4'd6)
                     && (month_acc_next >= 7'd1) && (month_acc_next <= 7'd12)
                     && (day_acc_next >= 7'd1)
                     && (day_acc_next <= 7'(month_length(month_acc_next[3:0],
                                                         year_acc_next[1:0] == 2'b00)))
                     && (hour_acc_next <= 7'd23) && (minute_acc_next <= 7'd59)
                     && (second_acc_next <= 7'd59) && (ms_sum <= MsLimit);

  always_comb begin
    result_next = '0;
    if (record_ok) begin
      result_next.ok          = 1'b1;
      result_next.year        = full_year;
      result_next.month       = month_acc_next[3:0];
      result_next.day         = day_acc_next[4:0];
      result_next.hour        = hour_acc_next[4:0];
      result_next.minute      = minute_acc_next[5:0];
      result_next.second      = second_acc_next[5:0];
      result_next.millisecond = ms_sum[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && char_reg.last)) begin
      in_time_phase <= 1'b0;
      date_count    <= 3'd0;
      time_count    <= 4'd0;
      day_acc       <= 7'd0;
      month_acc     <= 7'd0;
      year_acc      <= 7'd0;
      hour_acc      <= 7'd0;
      minute_acc    <= 7'd0;
      second_acc    <= 7'd0;
      fraction_acc  <= 10'd0;
      round_up      <= 1'b0;
      bad_flag      <= 1'b0;
    end else if (advance) begin
      in_time_phase <= in_time_phase_next;
      date_count    <= date_count_next;
      time_count    <= time_count_next;
      day_acc       <= day_acc_next;
      month_acc     <= month_acc_next;
      year_acc      <= year_acc_next;
      hour_acc      <= hour_acc_next;
      minute_acc    <= minute_acc_next;
      second_acc    <= second_acc_next;
      fraction_acc  <= fraction_acc_next;
      round_up      <= round_up_next;
      bad_flag      <= bad_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && char_reg.last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (advance && char_reg.last) begin
      out_data <= result_next;
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_data;

  `TDFP_ASSERT_NOW(a_invalid_zero, clk, rst, out_valid && !out_data.ok,
    out_data.year == 12'd0 && out_data.month == 4'd0 && out_data.day == 5'd0
    && out_data.hour == 5'd0 && out_data.millisecond == 10'd0,
    "Invalid result carries nonzero fields.")
  `TDFP_ASSERT_NOW(a_valid_range, clk, rst, out_valid && out_data.ok,
    out_data.month >= 4'd1 && out_data.month <= 4'd12 && out_data.day >= 5'd1
    && out_data.millisecond <= 10'd999 && out_data.year >= 12'd1950,
    "Valid result out of range.")
  `TDFP_ASSERT_NEXT(a_record_clear, clk, rst, advance && char_reg.last,
    out_valid && date_count == 3'd0 && time_count == 4'd0 && !in_time_phase && !bad_flag,
    "Record state not cleared after the last character.")
  `TDFP_ASSERT_NOW(a_last_waits, clk, rst, char_valid && char_reg.last && out_valid
    && !result.ready, !chars.ready, "Last character advanced over a held result.")

endmodule

`default_nettype wire
